// ===== hdl/htd_pkg.sv =====
// ----------------------------------------------------------------------------
// htd_pkg
// Shared types and constants of the huffman tree decoder: commands, result
// status codes, the queued item, the result record and back-end control.
// ----------------------------------------------------------------------------
package htd_pkg;

   localparam int BYTE_BITS      = 8;
   localparam int CODE_BITS      = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_LOAD   = 2'd1,
      CMD_DECODE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_SYMBOL  = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_LOAD_STEP,
      B_LOAD_WAIT,
      B_DEC,
      B_DONE
   } back_state_type;

   // classified item as it travels from the front to the back
   typedef struct packed {
      cmd_type     kind;
      logic [7:0]  sym;
      logic [5:0]  len;
      logic [31:0] code;
      logic [7:0]  data;
      logic        fin;
      logic [3:0]  nbits;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] sym;
      status_type status;
   } result_type;

   typedef struct packed {
      logic idle;
      logic item_end;
   } back_status_type;

endpackage

// ===== hdl/htd_front.sv =====
// ----------------------------------------------------------------------------
// htd_front
// Request acceptance and classification: saturates the code length, works out
// the number of used bits of a data byte and drops unused commands.
// ----------------------------------------------------------------------------
module htd_front #(
   parameter int MAX_CODE_BITS = 32
) (
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_cmd,
   input  logic [7:0]        req_symbol_in,
   input  logic [5:0]        req_code_len,
   input  logic [31:0]       req_code_bits,
   input  logic [7:0]        req_data_byte,
   input  logic              req_final_byte,
   input  logic [3:0]        req_pad_bits,
   input  logic              q_full,
   output logic              q_push,
   output htd_pkg::item_type q_item
);

   logic       accept;
   logic [5:0] len_sat;
   logic [3:0] nbits;

   assign busy   = q_full;
   assign accept = start && !busy;
   assign q_push = accept && (htd_pkg::cmd_type'(req_cmd) != htd_pkg::CMD_NONE);

   always_comb begin
      if ({1'b0, req_code_len} > 7'(MAX_CODE_BITS)) begin
         len_sat = 6'(MAX_CODE_BITS);
      end else begin
         len_sat = req_code_len;
      end
   end

   always_comb begin
      if (!req_final_byte) begin
         nbits = 4'(htd_pkg::BYTE_BITS);
      end else if (req_pad_bits >= 4'(htd_pkg::BYTE_BITS)) begin
         nbits = 4'd0;
      end else begin
         nbits = 4'(htd_pkg::BYTE_BITS) - req_pad_bits;
      end
   end

   always_comb begin
      q_item.kind  = htd_pkg::cmd_type'(req_cmd);
      q_item.sym   = req_symbol_in;
      q_item.len   = len_sat;
      q_item.code  = req_code_bits;
      q_item.data  = req_data_byte;
      q_item.fin   = req_final_byte;
      q_item.nbits = nbits;
   end

endmodule

// ===== hdl/htd_queue.sv =====
// ----------------------------------------------------------------------------
// htd_queue
// Short item queue between the front and the back; the head is shown while
// the queue is not empty.
// ----------------------------------------------------------------------------
module htd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  htd_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output htd_pkg::item_type head
);

   htd_pkg::item_type                   slot_ff [htd_pkg::QUEUE_DEPTH];
   logic [htd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [htd_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [htd_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                                do_push, do_pop;

   assign full    = count_ff == htd_pkg::QUEUE_CNT_BITS'(htd_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + htd_pkg::QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + htd_pkg::QUEUE_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + htd_pkg::QUEUE_CNT_BITS'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - htd_pkg::QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/htd_back.sv =====
// ----------------------------------------------------------------------------
// htd_back
// Tree engine: holds the node memory, inserts codes node by node and walks
// the tree one data bit per memory read.
// ----------------------------------------------------------------------------
module htd_back #(
   parameter int NODE_COUNT = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  htd_pkg::item_type        head,
   output logic                     q_pop,
   output htd_pkg::result_type      res,
   output htd_pkg::back_status_type bstat
);

   localparam int AW  = $clog2(NODE_COUNT);
   localparam int NUW = $clog2(NODE_COUNT + 1);
   localparam int EW  = 2 * AW + 8;

   htd_pkg::back_state_type state_ff, state_in;

   // root children live in flops so the tree is defined right after reset
   logic [AW-1:0]  root_left_ff, root_left_in;
   logic [AW-1:0]  root_right_ff, root_right_in;
   logic [NUW-1:0] nodes_used_ff, nodes_used_in;
   logic [AW-1:0]  walk_ff, walk_in;
   logic [AW-1:0]  node_ff, node_in;
   logic [AW-1:0]  cur_left_ff, cur_left_in;
   logic [AW-1:0]  cur_right_ff, cur_right_in;
   logic [7:0]     cur_sym_ff, cur_sym_in;
   logic [7:0]     ld_sym_ff, ld_sym_in;
   logic [31:0]    code_ff, code_in;
   logic [5:0]     rem_ff, rem_in;
   logic [7:0]     sh_ff, sh_in;
   logic           fin_ff, fin_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  pend_idx_ff, pend_idx_in;

   logic [EW-1:0]  mem [NODE_COUNT];
   logic [EW-1:0]  rdata_ff;
   logic [AW-1:0]  raddr;
   logic           we;
   logic [AW-1:0]  waddr;
   logic [EW-1:0]  wdata;

   logic [AW-1:0]  rd_left, rd_right;
   logic [7:0]     rd_sym;
   logic [5:0]     ld_pos;
   logic           ld_bit;
   logic [AW-1:0]  ld_child;
   logic [AW-1:0]  alloc_idx;
   logic           store_full;
   logic           leaf_hit;
   logic [AW-1:0]  eff_idx, eff_left, eff_right;
   logic [AW-1:0]  dec_nxt;

   assign rd_left    = rdata_ff[EW-1 -: AW];
   assign rd_right   = rdata_ff[AW+7 -: AW];
   assign rd_sym     = rdata_ff[7:0];

   assign ld_pos     = rem_ff - 6'd1;
   assign ld_bit     = ld_pos[5] ? 1'b0 : code_ff[ld_pos[4:0]];
   assign ld_child   = ld_bit ? cur_right_ff : cur_left_ff;
   assign alloc_idx  = nodes_used_ff[AW-1:0];
   assign store_full = nodes_used_ff == NUW'(NODE_COUNT);

   // node the walk stands on this cycle, after the pending read is resolved
   always_comb begin
      leaf_hit = pend_ff && (rd_left == '0) && (rd_right == '0);
      priority if (pend_ff && !leaf_hit) begin
         eff_idx   = pend_idx_ff;
         eff_left  = rd_left;
         eff_right = rd_right;
      end else if (pend_ff || (walk_ff == '0)) begin
         eff_idx   = '0;
         eff_left  = root_left_ff;
         eff_right = root_right_ff;
      end else begin
         eff_idx   = walk_ff;
         eff_left  = cur_left_ff;
         eff_right = cur_right_ff;
      end
      dec_nxt = sh_ff[7] ? eff_right : eff_left;
   end

   always_comb begin
      state_in      = state_ff;
      root_left_in  = root_left_ff;
      root_right_in = root_right_ff;
      nodes_used_in = nodes_used_ff;
      walk_in       = walk_ff;
      node_in       = node_ff;
      cur_left_in   = cur_left_ff;
      cur_right_in  = cur_right_ff;
      cur_sym_in    = cur_sym_ff;
      ld_sym_in     = ld_sym_ff;
      code_in       = code_ff;
      rem_in        = rem_ff;
      sh_in         = sh_ff;
      fin_in        = fin_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      raddr         = '0;
      we            = 1'b0;
      waddr         = '0;
      wdata         = '0;
      q_pop         = 1'b0;
      res.valid     = 1'b0;
      res.sym       = 8'd0;
      res.status    = htd_pkg::ST_SYMBOL;
      bstat.idle     = 1'b0;
      bstat.item_end = 1'b0;

      unique case (state_ff)
         htd_pkg::B_IDLE: begin
            bstat.idle = 1'b1;
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (head.kind)
                  htd_pkg::CMD_CLEAR: begin
                     root_left_in  = '0;
                     root_right_in = '0;
                     nodes_used_in = NUW'(1);
                     walk_in       = '0;
                     state_in      = htd_pkg::B_DONE;
                  end
                  htd_pkg::CMD_LOAD: begin
                     node_in      = '0;
                     cur_left_in  = root_left_ff;
                     cur_right_in = root_right_ff;
                     ld_sym_in    = head.sym;
                     code_in      = head.code;
                     rem_in       = head.len;
                     state_in     = htd_pkg::B_LOAD_STEP;
                  end
                  htd_pkg::CMD_DECODE: begin
                     sh_in  = head.data;
                     rem_in = {2'b00, head.nbits};
                     fin_in = head.fin;
                     // a load may have grown the node the walk stopped on: refetch it
                     if (walk_ff != '0) begin
                        raddr       = walk_ff;
                        pend_in     = 1'b1;
                        pend_idx_in = walk_ff;
                     end
                     state_in = htd_pkg::B_DEC;
                  end
                  htd_pkg::CMD_NONE: begin
                     state_in = htd_pkg::B_DONE;
                  end
                  default: begin
                     state_in = htd_pkg::B_DONE;
                  end
               endcase
            end
         end

         htd_pkg::B_LOAD_STEP: begin
            if (rem_ff == 6'd0) begin
               if (node_ff != '0) begin
                  we    = 1'b1;
                  waddr = node_ff;
                  wdata = {cur_left_ff, cur_right_ff, ld_sym_ff};
               end
               state_in = htd_pkg::B_DONE;
            end else if (ld_child != '0) begin
               raddr    = ld_child;
               node_in  = ld_child;
               rem_in   = rem_ff - 6'd1;
               state_in = htd_pkg::B_LOAD_WAIT;
            end else if (store_full) begin
               res.valid  = 1'b1;
               res.status = htd_pkg::ST_FULL;
               // a freshly allocated node still lives only in the cursor registers
               if (node_ff != '0) begin
                  we    = 1'b1;
                  waddr = node_ff;
                  wdata = {cur_left_ff, cur_right_ff, cur_sym_ff};
               end
               state_in = htd_pkg::B_DONE;
            end else begin
               if (node_ff == '0) begin
                  if (ld_bit) begin
                     root_right_in = alloc_idx;
                  end else begin
                     root_left_in = alloc_idx;
                  end
               end else begin
                  we    = 1'b1;
                  waddr = node_ff;
                  wdata = {ld_bit ? cur_left_ff : alloc_idx,
                           ld_bit ? alloc_idx : cur_right_ff,
                           cur_sym_ff};
               end
               node_in       = alloc_idx;
               cur_left_in   = '0;
               cur_right_in  = '0;
               cur_sym_in    = 8'd0;
               nodes_used_in = nodes_used_ff + NUW'(1);
               rem_in        = rem_ff - 6'd1;
            end
         end

         htd_pkg::B_LOAD_WAIT: begin
            cur_left_in  = rd_left;
            cur_right_in = rd_right;
            cur_sym_in   = rd_sym;
            state_in     = htd_pkg::B_LOAD_STEP;
         end

         htd_pkg::B_DEC: begin
            if (leaf_hit) begin
               res.valid  = 1'b1;
               res.sym    = rd_sym;
               res.status = htd_pkg::ST_SYMBOL;
            end
            if (rem_ff != 6'd0) begin
               if (dec_nxt == '0) begin
                  walk_in = '0;
                  pend_in = 1'b0;
                  // one result per cycle: after a leaf, the miss reports next cycle
                  if (!leaf_hit) begin
                     res.valid  = 1'b1;
                     res.sym    = 8'd0;
                     res.status = htd_pkg::ST_MISSING;
                     sh_in      = {sh_ff[6:0], 1'b0};
                     rem_in     = rem_ff - 6'd1;
                  end
               end else begin
                  raddr        = dec_nxt;
                  pend_in      = 1'b1;
                  pend_idx_in  = dec_nxt;
                  walk_in      = eff_idx;
                  cur_left_in  = eff_left;
                  cur_right_in = eff_right;
                  sh_in        = {sh_ff[6:0], 1'b0};
                  rem_in       = rem_ff - 6'd1;
               end
            end else begin
               pend_in      = 1'b0;
               walk_in      = fin_ff ? '0 : eff_idx;
               cur_left_in  = eff_left;
               cur_right_in = eff_right;
               state_in     = htd_pkg::B_DONE;
            end
         end

         htd_pkg::B_DONE: begin
            bstat.item_end = 1'b1;
            state_in       = htd_pkg::B_IDLE;
         end

         default: begin
            state_in = htd_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= htd_pkg::B_IDLE;
         root_left_ff  <= '0;
         root_right_ff <= '0;
         nodes_used_ff <= NUW'(1);
         walk_ff       <= '0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_left_ff  <= root_left_in;
         root_right_ff <= root_right_in;
         nodes_used_ff <= nodes_used_in;
         walk_ff       <= walk_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      cur_left_ff <= cur_left_in;
      cur_right_ff <= cur_right_in;
      cur_sym_ff  <= cur_sym_in;
      ld_sym_ff   <= ld_sym_in;
      code_ff     <= code_in;
      rem_ff      <= rem_in;
      sh_ff       <= sh_in;
      fin_ff      <= fin_in;
      pend_idx_ff <= pend_idx_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

endmodule

// ===== hdl/htd_emit.sv =====
// ----------------------------------------------------------------------------
// htd_emit
// Result output stage: holds back one result so that the last result of an
// item can be marked when the item ends.
// ----------------------------------------------------------------------------
module htd_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  htd_pkg::result_type      res,
   input  htd_pkg::back_status_type bstat,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_symbol_out,
   output logic [1:0]               rsp_status,
   output logic                     rsp_run_last
);

   logic                hold_valid_ff, hold_valid_in;
   logic [7:0]          hold_sym_ff, hold_sym_in;
   htd_pkg::status_type hold_status_ff, hold_status_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_sym_ff, out_sym_in;
   htd_pkg::status_type out_status_ff, out_status_in;
   logic                out_last_ff, out_last_in;

   always_comb begin
      hold_valid_in  = hold_valid_ff;
      hold_sym_in    = hold_sym_ff;
      hold_status_in = hold_status_ff;
      out_valid_in   = 1'b0;
      out_sym_in     = hold_sym_ff;
      out_status_in  = hold_status_ff;
      out_last_in    = 1'b0;
      if (res.valid) begin
         out_valid_in   = hold_valid_ff;
         hold_valid_in  = 1'b1;
         hold_sym_in    = res.sym;
         hold_status_in = res.status;
      end else if (bstat.item_end) begin
         out_valid_in  = hold_valid_ff;
         out_last_in   = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_sym_ff    <= hold_sym_in;
      hold_status_ff <= hold_status_in;
      out_sym_ff     <= out_sym_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_symbol_out = out_sym_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_run_last   = out_last_ff;

endmodule

// ===== hdl/huffman_tree_decoder_core.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_decoder_core
// Huffman decoder with a loadable code tree walked one bit per node read.
// ----------------------------------------------------------------------------
// Usage: a command is transferred at a rising edge with start high and busy
// low. Clear empties the tree, load inserts one symbol along its code, decode
// walks the tree with one byte, most significant bit first; cmd 3 is taken
// and dropped. Commands enter a two-entry queue; busy is high while it is full.
// Each result is shown for one cycle with rsp_valid high; rsp_run_last marks
// the last result of a command. The receiver cannot stall, so results flow
// out at the rate the tree engine makes them.
// Timing: the walk reads the node memory for each data bit that leads to an
// existing node; a missing branch that follows a symbol is reported after
// that symbol's result. A load reads each existing node along its code and
// writes each node it changes; a clear resets the root, node count and walk.
// A result is held until the next result of the same command or the end of
// the command, and shows in the cycle after. Reset leaves an empty tree (root
// without children, walk at the root); the node memory is not swept and holds
// no data until loads write it.
module huffman_tree_decoder_core #(
   parameter int NODE_COUNT    = 1024,
   parameter int MAX_CODE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_symbol_in,
   input  logic [5:0]  req_code_len,
   input  logic [31:0] req_code_bits,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   input  logic [3:0]  req_pad_bits,
   output logic        rsp_valid,
   output logic [7:0]  rsp_symbol_out,
   output logic [1:0]  rsp_status,
   output logic        rsp_run_last
);

   logic                     q_full, q_push, q_pop, q_empty;
   htd_pkg::item_type        q_item, q_head;
   htd_pkg::result_type      res;
   htd_pkg::back_status_type bstat;

   htd_front #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_front (
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_symbol_in  (req_symbol_in),
      .req_code_len   (req_code_len),
      .req_code_bits  (req_code_bits),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .req_pad_bits   (req_pad_bits),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (q_item)
   );

   htd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   htd_back #(
      .NODE_COUNT (NODE_COUNT)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .head    (q_head),
      .q_pop   (q_pop),
      .res     (res),
      .bstat   (bstat)
   );

   htd_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .res            (res),
      .bstat          (bstat),
      .rsp_valid      (rsp_valid),
      .rsp_symbol_out (rsp_symbol_out),
      .rsp_status     (rsp_status),
      .rsp_run_last   (rsp_run_last)
   );

`ifndef SYNTH
   // the end-of-command marker must never collide with a fresh result
   assert property (@(posedge clock) disable iff (reset)
      res.valid |-> !bstat.item_end)
      else $error("result produced in the item end cycle");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (bstat.idle && !q_empty))
      else $error("queue popped while the tree engine is busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != htd_pkg::ST_SYMBOL)) |-> (rsp_symbol_out == 8'd0))
      else $error("error result carries a nonzero symbol");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == htd_pkg::ST_SYMBOL || rsp_status == htd_pkg::ST_MISSING ||
                     rsp_status == htd_pkg::ST_FULL))
      else $error("undefined result status");
`endif

endmodule

// ===== tb/htd_checker.sv =====
// ----------------------------------------------------------------------------
// htd_checker
// Watches both channels of the huffman tree decoder, keeps its own copy of
// the code tree and the walk position, predicts the results of every command
// transfer and compares each result transfer field by field, oldest first.
// ----------------------------------------------------------------------------
module htd_checker #(
   parameter int NODE_COUNT    = 1024,
   parameter int MAX_CODE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_symbol_in,
   input  logic [5:0]  req_code_len,
   input  logic [31:0] req_code_bits,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   input  logic [3:0]  req_pad_bits,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_symbol_out,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_run_last,
   output int          failures,
   output int          pending
);

   typedef struct packed {
      logic [7:0]          sym;
      htd_pkg::status_type status;
      logic                last;
   } decoded_type;

   logic [9:0]  left_kid  [NODE_COUNT];
   logic [9:0]  right_kid [NODE_COUNT];
   logic [7:0]  leaf_sym  [NODE_COUNT];
   int          nodes_taken = 1;
   int          walk_at = 0;
   int          errs = 0;
   decoded_type owed_results [$];
   decoded_type made_now [$];

   task automatic empty_tree();
      left_kid[0]  = '0;
      right_kid[0] = '0;
      nodes_taken  = 1;
      walk_at      = 0;
   endtask

   // insert one code, msb first; stops with a full status when no node is left
   task automatic grow_path(input logic [7:0] sym, input logic [5:0] len,
                            input logic [31:0] code);
      int   depth;
      int   node;
      int   next_node;
      logic go_right;
      depth = (len > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(len);
      node  = 0;
      for (int i = 0; i < depth; i++) begin
         go_right  = code[depth - 1 - i];
         next_node = go_right ? right_kid[node] : left_kid[node];
         if (next_node == 0) begin
            if (nodes_taken >= NODE_COUNT) begin
               made_now.push_back('{sym: 8'd0, status: htd_pkg::ST_FULL, last: 1'b0});
               return;
            end
            next_node = nodes_taken;
            nodes_taken++;
            left_kid[next_node]  = '0;
            right_kid[next_node] = '0;
            leaf_sym[next_node]  = '0;
            if (go_right) begin
               right_kid[node] = 10'(next_node);
            end else begin
               left_kid[node] = 10'(next_node);
            end
         end
         node = next_node;
      end
      leaf_sym[node] = sym;
   endtask

   task automatic walk_byte(input logic [7:0] data, input logic fin, input logic [3:0] pad);
      int used_bits;
      int next_node;
      used_bits = htd_pkg::BYTE_BITS;
      if (fin) begin
         used_bits = (pad >= htd_pkg::BYTE_BITS) ? 0 : htd_pkg::BYTE_BITS - int'(pad);
      end
      for (int i = 0; i < used_bits; i++) begin
         next_node = data[htd_pkg::BYTE_BITS - 1 - i] ? right_kid[walk_at] : left_kid[walk_at];
         if (next_node == 0) begin
            made_now.push_back('{sym: 8'd0, status: htd_pkg::ST_MISSING, last: 1'b0});
            walk_at = 0;
         end else if (left_kid[next_node] == 0 && right_kid[next_node] == 0) begin
            made_now.push_back('{sym: leaf_sym[next_node], status: htd_pkg::ST_SYMBOL,
                                 last: 1'b0});
            walk_at = 0;
         end else begin
            walk_at = next_node;
         end
      end
      // a partial code left at the end of the stream is dropped
      if (fin) begin
         walk_at = 0;
      end
   endtask

   task automatic report(input string what, input int exp_v, input int got_v);
      errs++;
      $display("%0t %s: expected %0d, got %0d", $time, what, exp_v, got_v);
   endtask

   always @(posedge clock) begin
      decoded_type want;
      if (reset) begin
         empty_tree();
         owed_results.delete();
      end else begin
         // results of this edge belong to earlier commands
         if (rsp_valid) begin
            if (owed_results.size() == 0) begin
               errs++;
               $display("%0t result transfer with none expected: symbol %0d status %0d",
                        $time, rsp_symbol_out, rsp_status);
            end else begin
               want = owed_results.pop_front();
               if (rsp_symbol_out !== want.sym) begin
                  report("symbol_out", want.sym, rsp_symbol_out);
               end
               if (rsp_status !== want.status) begin
                  report("status", want.status, rsp_status);
               end
               if (rsp_run_last !== want.last) begin
                  report("run_last", want.last, rsp_run_last);
               end
            end
         end
         if (start && !busy) begin
            made_now.delete();
            unique case (htd_pkg::cmd_type'(req_cmd))
               htd_pkg::CMD_CLEAR: begin
                  empty_tree();
               end
               htd_pkg::CMD_LOAD: begin
                  grow_path(req_symbol_in, req_code_len, req_code_bits);
               end
               htd_pkg::CMD_DECODE: begin
                  walk_byte(req_data_byte, req_final_byte, req_pad_bits);
               end
               default: ;
            endcase
            foreach (made_now[i]) begin
               want      = made_now[i];
               want.last = (i == made_now.size() - 1);
               owed_results.push_back(want);
            end
         end
      end
      failures <= errs;
      pending  <= owed_results.size();
   end

endmodule

// ===== tb/huffman_tree_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_decoder_core_test
// Stimulus and verdict for the huffman tree decoder. A directed run covers
// empty trees, leaves turned into inner nodes, root-only codes, saturated
// code lengths and pads, and partial codes across bytes. Random phases then
// load prefix-free code sets and decode streams made from them, fill the node
// store, or send random commands. htd_checker predicts and compares.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_core_test;

   localparam int NODES       = 1024;
   localparam int CODE_MAX    = 32;
   localparam int ITEM_GOAL   = 130;
   localparam int DRAIN       = 150;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd        = htd_pkg::CMD_NONE;
   logic [7:0]  req_symbol_in  = '0;
   logic [5:0]  req_code_len   = '0;
   logic [31:0] req_code_bits  = '0;
   logic [7:0]  req_data_byte  = '0;
   logic        req_final_byte = 1'b0;
   logic [3:0]  req_pad_bits   = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_symbol_out;
   logic [1:0]  rsp_status;
   logic        rsp_run_last;
   int          failures;
   int          pending;
   int          sent = 0;
   int          cycles = 0;
   bit          steady = 1'b0;

   // prefix-free code set of the current phase
   int          cw_len  [$];
   logic [31:0] cw_bits [$];
   logic [7:0]  cw_sym  [$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   huffman_tree_decoder_core #(
      .NODE_COUNT    (NODES),
      .MAX_CODE_BITS (CODE_MAX)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_symbol_in  (req_symbol_in),
      .req_code_len   (req_code_len),
      .req_code_bits  (req_code_bits),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .req_pad_bits   (req_pad_bits),
      .rsp_valid      (rsp_valid),
      .rsp_symbol_out (rsp_symbol_out),
      .rsp_status     (rsp_status),
      .rsp_run_last   (rsp_run_last)
   );

   htd_checker #(
      .NODE_COUNT    (NODES),
      .MAX_CODE_BITS (CODE_MAX)
   ) u_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_symbol_in  (req_symbol_in),
      .req_code_len   (req_code_len),
      .req_code_bits  (req_code_bits),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .req_pad_bits   (req_pad_bits),
      .rsp_valid      (rsp_valid),
      .rsp_symbol_out (rsp_symbol_out),
      .rsp_status     (rsp_status),
      .rsp_run_last   (rsp_run_last),
      .failures       (failures),
      .pending        (pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // one command transfer, with random idle cycles ahead of it unless steady is set
   task automatic send(input htd_pkg::cmd_type c, input logic [7:0] sym,
                       input logic [5:0] len, input logic [31:0] code,
                       input logic [7:0] data, input logic fin, input logic [3:0] pad);
      while (!steady && $urandom_range(99) < 24) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= c;
      req_symbol_in  <= sym;
      req_code_len   <= len;
      req_code_bits  <= code;
      req_data_byte  <= data;
      req_final_byte <= fin;
      req_pad_bits   <= pad;
      do @(posedge clock); while (busy);
      if (c != htd_pkg::CMD_NONE) begin
         sent++;
      end
   endtask

   task automatic send_clear();
      send(htd_pkg::CMD_CLEAR, 8'($urandom), 6'($urandom), $urandom, 8'($urandom),
           1'($urandom), 4'($urandom));
   endtask

   task automatic send_load(input logic [7:0] sym, input logic [5:0] len,
                            input logic [31:0] code);
      send(htd_pkg::CMD_LOAD, sym, len, code, 8'($urandom), 1'($urandom), 4'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] data, input logic fin, input logic [3:0] pad);
      send(htd_pkg::CMD_DECODE, 8'($urandom), 6'($urandom), $urandom, data, fin, pad);
   endtask

   // random full binary tree: split leaves until the set is big enough or the tries run out
   task automatic grow_code_set();
      int want;
      int cap;
      int k;
      int tries;
      cw_len.delete();
      cw_bits.delete();
      cw_sym.delete();
      cw_len.push_back(0);
      cw_bits.push_back('0);
      want  = $urandom_range(2, 16);
      cap   = $urandom_range(3, 14);
      tries = 0;
      while (cw_len.size() < want && tries < 200) begin
         k = $urandom_range(cw_len.size() - 1);
         if (cw_len[k] < cap) begin
            cw_len.push_back(cw_len[k] + 1);
            cw_bits.push_back({cw_bits[k][30:0], 1'b1});
            cw_len[k]++;
            cw_bits[k] = {cw_bits[k][30:0], 1'b0};
         end
         tries++;
      end
      foreach (cw_len[i]) begin
         cw_sym.push_back(8'($urandom));
      end
   endtask

   // loads the set in random order; a dropped code leaves a missing branch
   task automatic load_code_set(input bit drop_one);
      int order [$];
      int j;
      int t;
      int skip;
      foreach (cw_len[i]) begin
         order.push_back(i);
      end
      for (int i = order.size() - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      skip = drop_one ? order[0] : -1;
      foreach (order[i]) begin
         if (order[i] != skip) begin
            send_load(cw_sym[order[i]], 6'(cw_len[order[i]]), cw_bits[order[i]]);
         end
      end
   endtask

   task automatic decode_stream();
      bit         stream [$];
      int         m;
      int         k;
      int         take;
      int         cut;
      logic [7:0] chunk;
      bit         fin_flag;
      m = $urandom_range(1, 12);
      repeat (m) begin
         k = $urandom_range(cw_len.size() - 1);
         for (int b = cw_len[k] - 1; b >= 0; b--) begin
            stream.push_back(cw_bits[k][b]);
         end
      end
      // sometimes a trailing partial code
      if ($urandom_range(3) == 0) begin
         k   = $urandom_range(cw_len.size() - 1);
         cut = $urandom_range(cw_len[k] - 1);
         for (int b = cw_len[k] - 1; b >= cw_len[k] - cut; b--) begin
            stream.push_back(cw_bits[k][b]);
         end
      end
      fin_flag = ($urandom_range(4) != 0);
      while (stream.size() > 0) begin
         take  = (stream.size() < 8) ? stream.size() : 8;
         chunk = '0;
         for (int b = 0; b < take; b++) begin
            chunk[7 - b] = stream.pop_front();
         end
         if ($urandom_range(9) == 0) begin
            chunk = 8'($urandom);
         end
         if (stream.size() == 0 && fin_flag) begin
            send_byte(chunk, 1'b1, 4'(8 - take));
         end else begin
            send_byte(chunk, 1'b0, 4'($urandom));
         end
      end
   endtask

   initial begin
      int phase;
      phase = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // walk on the tree left by reset: every bit is a missing branch
      send_byte(8'hA5, 1'b0, 4'd0);
      send_load(8'h41, 6'd1, 32'h0);
      send_load(8'h42, 6'd2, 32'h2);
      send_load(8'h43, 6'd2, 32'h3);
      send_byte(8'h00, 1'b0, 4'd0);
      send_byte(8'hFF, 1'b0, 4'd0);
      // ends halfway down a code, next byte resumes below the root
      send_byte(8'h55, 1'b0, 4'd9);
      send_byte(8'h80, 1'b1, 4'd7);
      // partial code dropped at the end of a stream
      send_byte(8'h80, 1'b1, 4'd7);
      send_byte(8'h00, 1'b0, 4'd0);
      send_byte(8'hE0, 1'b1, 4'd15);
      send_byte(8'hFF, 1'b1, 4'd8);
      send_byte(8'hFF, 1'b1, 4'd0);
      // an existing leaf turns into an inner node
      send_load(8'h44, 6'd3, 32'h0);
      send_byte(8'h40, 1'b0, 4'd0);
      send_byte(8'h20, 1'b1, 4'd0);
      // zero-length code leaves the tree as it is
      send_load(8'hEE, 6'd0, 32'hFFFF_FFFF);
      // length above the limit saturates
      send_load(8'hFF, 6'd63, 32'hFFFF_FFFF);
      send_byte(8'hFF, 1'b0, 4'd0);
      send_byte(8'hFF, 1'b1, 4'd0);
      send(htd_pkg::CMD_NONE, 8'hFF, 6'd63, 32'hFFFF_FFFF, 8'hFF, 1'b1, 4'd15);
      send_clear();
      send_byte(8'hFF, 1'b1, 4'd4);
      send_load(8'h80, 6'd32, 32'h8000_0001);
      send_byte(8'h80, 1'b0, 4'd0);

      while (sent < ITEM_GOAL) begin
         steady = (sent >= 80 && sent < 120);
         if (phase == 2 || $urandom_range(19) == 0) begin
            // long codes until the node store runs out
            send_clear();
            repeat (45) send_load(8'($urandom), 6'($urandom_range(32, 63)), $urandom);
            repeat (4) send_byte(8'($urandom), 1'($urandom), 4'($urandom));
         end else if ($urandom_range(6) == 0) begin
            repeat ($urandom_range(4, 10)) begin
               send(htd_pkg::cmd_type'($urandom_range(3)), 8'($urandom), 6'($urandom),
                    $urandom, 8'($urandom), 1'($urandom), 4'($urandom));
            end
         end else begin
            send_clear();
            grow_code_set();
            load_code_set($urandom_range(4) == 0);
            repeat ($urandom_range(1, 3)) decode_stream();
         end
         phase++;
      end
      steady = 1'b0;
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
